@@ rtl/tlsf_pkg.sv @@
`timescale 1ns / 1ps

package tlsf_pkg;

	localparam int TLSF_MAX_FRAMES = 32;

	localparam int FRAME_W = 5;
	localparam int VAL_W   = 16;
	localparam int IDX_W   = 2;
	localparam int CNT_W   = 6;
	localparam int SY_W    = 22;
	localparam int SXY_W   = 27;
	localparam int SX_W    = 10;
	localparam int NSXY_W  = 32;
	localparam int D_W     = 17;
	localparam int Q_W     = 22;
	localparam int SYD_W   = 39;
	localparam int N_W     = 34;
	localparam int TM_W    = 12;
	localparam int P_W     = 48;
	localparam int MQ_W    = 38;
	localparam int REM_W   = 40;

	localparam int DIV_STEPS = VAL_W;
	localparam int DTAB_N    = 33;

	typedef enum logic [IDX_W-1:0] {
		REG_FIRST  = 2'd0,
		REG_LAST   = 2'd1,
		REG_TARGET = 2'd2,
		REG_MAX    = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic acc;
		logic clr;
		logic st_a;
		logic st_b;
		logic st_c;
		logic st_d;
		logic div_step;
		logic load_out;
	} tlsf_cmd_t;

	typedef struct packed {
		logic last;
		logic need_div;
	} tlsf_stat_t;

	typedef logic [D_W-1:0] dtab_t [DTAB_N];

	// n*Sxx - Sx*Sx over n consecutive indices, independent of the start index
	function automatic dtab_t build_dtab();
		dtab_t t;
		for (int k = 0; k < DTAB_N; k++) begin
			t[k] = D_W'((k * k * (k * k - 1)) / 12);
		end
		return t;
	endfunction

	localparam dtab_t D_TABLE = build_dtab();

endpackage

@@ rtl/tlsf_ctrl.sv @@
`timescale 1ns / 1ps

module tlsf_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	output logic                   out_valid,
	input  logic                   out_ready,
	output tlsf_pkg::tlsf_cmd_t    cmd,
	input  tlsf_pkg::tlsf_stat_t   stat
);
	import tlsf_pkg::*;

	localparam int DC_W = $clog2(DIV_STEPS);
	localparam logic [DC_W-1:0] DIV_LAST = DC_W'(DIV_STEPS - 1);

	typedef enum logic [2:0] {
		S_ACC, S_A, S_B, S_C, S_D, S_DIV, S_DONE
	} state_t;

	state_t           state_q;
	logic [DC_W-1:0]  div_cnt_q;
	logic             out_valid_q;

	assign in_ready  = (state_q == S_ACC);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd          = '0;
		cmd.acc      = in_valid && in_ready;
		cmd.st_a     = (state_q == S_A);
		cmd.st_b     = (state_q == S_B);
		cmd.st_c     = (state_q == S_C);
		cmd.st_d     = (state_q == S_D);
		cmd.div_step = (state_q == S_DIV);
		cmd.load_out = (state_q == S_DONE) && (!out_valid_q || out_ready);
		cmd.clr      = cmd.load_out;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_ACC;
			div_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load_out)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				S_ACC: begin
					if (cmd.acc && stat.last)
						state_q <= S_A;
				end
				S_A: state_q <= S_B;
				S_B: state_q <= S_C;
				S_C: state_q <= S_D;
				S_D: begin
					div_cnt_q <= '0;
					state_q   <= stat.need_div ? S_DIV : S_DONE;
				end
				S_DIV: begin
					div_cnt_q <= div_cnt_q + DC_W'(1);
					if (div_cnt_q == DIV_LAST)
						state_q <= S_DONE;
				end
				S_DONE: begin
					if (cmd.load_out)
						state_q <= S_ACC;
				end
				default: state_q <= S_ACC;
			endcase
		end
	end

	a_div_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV && div_cnt_q == DIV_LAST) |=> (state_q == S_DONE))
		else $error("divider ran past its step count");

	a_last_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.acc && stat.last) |=> !in_ready)
		else $error("input taken while a fit is pending");

	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == S_DONE))
		else $error("result raised outside completion");

endmodule

@@ rtl/tlsf_dp.sv @@
`timescale 1ns / 1ps

module tlsf_dp #(
	parameter int MAX_FRAMES = tlsf_pkg::TLSF_MAX_FRAMES
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  tlsf_pkg::tlsf_cmd_t           cmd,
	output tlsf_pkg::tlsf_stat_t          stat,
	input  logic                          cfg_we,
	input  logic [tlsf_pkg::IDX_W-1:0]    cfg_index,
	input  logic [tlsf_pkg::VAL_W-1:0]    cfg_data,
	input  logic [tlsf_pkg::VAL_W-1:0]    sample,
	output logic [tlsf_pkg::VAL_W-1:0]    fitted_value
);
	import tlsf_pkg::*;

	logic [FRAME_W-1:0] first_q, last_q, target_q;
	logic [VAL_W-1:0]   max_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q  <= FRAME_W'(0);
			last_q   <= FRAME_W'(4);
			target_q <= FRAME_W'(2);
			max_q    <= VAL_W'(255);
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_FIRST:  first_q  <= cfg_data[FRAME_W-1:0];
				REG_LAST:   last_q   <= cfg_data[FRAME_W-1:0];
				REG_TARGET: target_q <= cfg_data[FRAME_W-1:0];
				REG_MAX:    max_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// window length, reversed window is one frame, capped at MAX_FRAMES
	logic [CNT_W-1:0] n_raw, n_len;
	always_comb begin
		n_raw = (last_q >= first_q) ?
			CNT_W'(last_q) - CNT_W'(first_q) + CNT_W'(1) : CNT_W'(1);
		n_len = (int'(n_raw) > MAX_FRAMES) ? CNT_W'(MAX_FRAMES) : n_raw;
	end

	// accumulation
	logic [CNT_W-1:0]       cnt_q;
	logic [SY_W-1:0]        sy_q;
	logic [SXY_W-1:0]       sxy_q;
	logic [CNT_W:0]         cnt_next;
	logic [CNT_W-1:0]       x;
	logic [CNT_W+VAL_W-1:0] xy;

	assign cnt_next = {1'b0, cnt_q} + (CNT_W+1)'(1);
	assign x        = CNT_W'(first_q) + cnt_q;
	assign xy       = (CNT_W+VAL_W)'(x) * (CNT_W+VAL_W)'(sample);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			sy_q  <= '0;
			sxy_q <= '0;
		end else if (cmd.clr) begin
			cnt_q <= '0;
			sy_q  <= '0;
			sxy_q <= '0;
		end else if (cmd.acc) begin
			cnt_q <= cnt_next[CNT_W-1:0];
			sy_q  <= sy_q + SY_W'(sample);
			sxy_q <= sxy_q + SXY_W'(xy);
		end
	end

	// step A: Sx, D, n*Sxy
	logic [SX_W-1:0]   sx_q;
	logic [D_W-1:0]    d_q;
	logic [NSXY_W-1:0] nsxy_q;
	logic [10:0]       nf;
	logic [11:0]       nn1;

	assign nf  = 11'(n_len) * 11'(first_q);
	assign nn1 = 12'(n_len) * 12'(n_len - CNT_W'(1));

	always_ff @(posedge clk) begin
		if (cmd.st_a) begin
			sx_q   <= SX_W'(nf + nn1[11:1]);
			d_q    <= D_TABLE[n_len];
			nsxy_q <= NSXY_W'(n_len) * NSXY_W'(sxy_q);
		end
	end

	// step B: N, Sy*D, q, t*n - Sx
	logic signed [N_W-1:0]  nbig_q;
	logic [SYD_W-1:0]       syd_q;
	logic [Q_W-1:0]         q_q;
	logic signed [TM_W-1:0] tm_q;
	logic [NSXY_W-1:0]      sxsy;

	assign sxsy = NSXY_W'(sx_q) * NSXY_W'(sy_q);

	always_ff @(posedge clk) begin
		if (cmd.st_b) begin
			nbig_q <= $signed(N_W'(nsxy_q)) - $signed(N_W'(sxsy));
			syd_q  <= SYD_W'(sy_q) * SYD_W'(d_q);
			q_q    <= Q_W'(n_len) * Q_W'(d_q);
			tm_q   <= $signed(TM_W'(target_q) * TM_W'(n_len)) - $signed(TM_W'(sx_q));
		end
	end

	// step C: numerator P and clamp bound max*q
	logic signed [P_W-1:0]      p_q;
	logic [MQ_W-1:0]            mxq_q;
	logic signed [N_W+TM_W-1:0] ntm;

	assign ntm = (N_W+TM_W)'(nbig_q) * (N_W+TM_W)'(tm_q);

	always_ff @(posedge clk) begin
		if (cmd.st_c) begin
			p_q   <= P_W'(ntm) + $signed(P_W'(syd_q));
			mxq_q <= MQ_W'(max_q) * MQ_W'(q_q);
		end
	end

	// step D and restoring divide, one quotient bit per cycle
	logic [REM_W-1:0] rem_q, dsr_q;
	logic [VAL_W-1:0] res_q, out_q;
	logic             two_plus, p_pos, p_below;
	logic             ge;
	logic [P_W:0]     p2q;

	assign two_plus = (n_len >= CNT_W'(2));
	assign p_pos    = (p_q > $signed(P_W'(0)));
	assign p_below  = (p_q < $signed(P_W'(mxq_q)));
	assign p2q      = {p_q[P_W-1:0], 1'b0} + (P_W+1)'(q_q);
	assign ge       = (rem_q >= dsr_q);

	assign stat.last     = (cnt_next >= {1'b0, n_len});
	assign stat.need_div = two_plus && p_pos && p_below;

	always_ff @(posedge clk) begin
		if (cmd.st_d) begin
			rem_q <= REM_W'(p2q);
			dsr_q <= REM_W'({q_q, 1'b0}) << (DIV_STEPS - 1);
			if (!two_plus)
				res_q <= (sy_q > SY_W'(max_q)) ? max_q : sy_q[VAL_W-1:0];
			else if (!p_pos)
				res_q <= '0;
			else if (!p_below)
				res_q <= max_q;
			else
				res_q <= '0;
		end else if (cmd.div_step) begin
			if (ge)
				rem_q <= rem_q - dsr_q;
			dsr_q <= dsr_q >> 1;
			res_q <= {res_q[VAL_W-2:0], ge};
		end
		if (cmd.load_out)
			out_q <= res_q;
	end

	assign fitted_value = out_q;

endmodule

@@ rtl/temporal_least_squares_fit_top.sv @@
`timescale 1ns / 1ps

// Temporal least-squares line fit. Samples of one pixel position arrive one
// per transfer, frame first_frame first; within a window a sample is taken
// every cycle that in_valid is high. After a window's last sample the fit
// runs steps A to D, plus the one-bit-per-cycle divider when the window has
// two or more samples and the value lies strictly between 0 and max_value;
// the input is held off meanwhile and until the output register is free.
// The rounded, clamped value is held in an output register until taken.
// Configuration writes are taken in any cycle and must only occur while idle.

module temporal_least_squares_fit_top #(
	parameter int MAX_FRAMES = tlsf_pkg::TLSF_MAX_FRAMES
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [tlsf_pkg::IDX_W-1:0]    cfg_index,
	input  logic [tlsf_pkg::VAL_W-1:0]    cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [tlsf_pkg::VAL_W-1:0]    sample,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [tlsf_pkg::VAL_W-1:0]    fitted_value
);
	import tlsf_pkg::*;

	tlsf_cmd_t  cmd;
	tlsf_stat_t stat;
	logic       cfg_we;

	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;

	tlsf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.stat      (stat)
	);

	tlsf_dp #(
		.MAX_FRAMES (MAX_FRAMES)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.sample       (sample),
		.fitted_value (fitted_value)
	);

endmodule
